>>> rtl/core/mtte_pkg.sv
// Package for the multi-tap text entry block: word types, action codes,
// key letter table and BCD increment. No dependencies.
package mtte_pkg;

   localparam int TEXT_LEN_DEF = 8;
   localparam int NUM_KEYS     = 9;
   localparam int OUT_CHARS    = 8;

   typedef logic [7:0] char_type;

   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_ZERO  = 8'h30;
   localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
   localparam logic [1:0] TAP_LAST      = 2'd2;

   // exact two-key combinations
   localparam logic [NUM_KEYS-1:0] MASK_TOGGLE = 9'h030;
   localparam logic [NUM_KEYS-1:0] MASK_CLEAR  = 9'h006;
   localparam logic [NUM_KEYS-1:0] MASK_SPACE  = 9'h180;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_TOGGLE = 3'd1;
   localparam logic [2:0] ACT_CLEAR  = 3'd2;
   localparam logic [2:0] ACT_SPACE  = 3'd3;
   localparam logic [2:0] ACT_KEY    = 3'd4;

   typedef struct packed {
      logic [2:0] act;
      logic [3:0] key;
   } action_type;

   typedef struct packed {
      logic [NUM_KEYS-1:0] key_mask;
   } req_word_type;

   typedef struct packed {
      char_type    char_0;
      char_type    char_1;
      char_type    char_2;
      char_type    char_3;
      char_type    char_4;
      char_type    char_5;
      char_type    char_6;
      char_type    char_7;
      logic        letter_mode;
      logic [15:0] press_count_bcd;
   } rsp_word_type;

   function automatic char_type key_letter(input logic [3:0] key, input logic [1:0] tap);
      logic [23:0] row;
      case (key)
         4'd0:    row = ".QZ";
         4'd1:    row = "ABC";
         4'd2:    row = "DEF";
         4'd3:    row = "GHI";
         4'd4:    row = "JKL";
         4'd5:    row = "MNO";
         4'd6:    row = "PRS";
         4'd7:    row = "TUV";
         default: row = "WXY";
      endcase
      case (tap)
         2'd0:    return row[23:16];
         2'd1:    return row[15:8];
         default: return row[7:0];
      endcase
   endfunction

   // digits above nine count as nine, as in the original counter
   function automatic logic [15:0] bcd_inc(input logic [15:0] v);
      logic [15:0] res;
      logic        carry;
      logic [3:0]  digit;
      res   = '0;
      carry = 1'b1;
      for (int d = 0; d < 4; d++) begin
         digit = v[4*d +: 4];
         if (digit > BCD_MAX_DIGIT) begin
            digit = BCD_MAX_DIGIT;
         end
         if (carry && digit == BCD_MAX_DIGIT) begin
            digit = 4'd0;
            carry = 1'b1;
         end else begin
            digit = digit + 4'(carry);
            carry = 1'b0;
         end
         res[4*d +: 4] = digit;
      end
      return res;
   endfunction

endpackage

>>> rtl/core/mtte_chan_if.sv
// Valid/ready channel carrying one word of a payload type.
// Payload types come from mtte_pkg.
interface mtte_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/mtte_key_decode.sv
// Key mask decoder: lowest pressed key and the three exact two-key actions.
// Uses mtte_pkg.
module mtte_key_decode (
   input  logic [mtte_pkg::NUM_KEYS-1:0] key_mask,
   output mtte_pkg::action_type          action
);

   logic [3:0] lo_key;

   always_comb begin
      lo_key = 4'd0;
      for (int i = mtte_pkg::NUM_KEYS - 1; i >= 0; i--) begin
         if (key_mask[i]) begin
            lo_key = 4'(i);
         end
      end
   end

   always_comb begin
      action.key = lo_key;
      if (key_mask == mtte_pkg::MASK_TOGGLE) begin
         action.act = mtte_pkg::ACT_TOGGLE;
      end else if (key_mask == mtte_pkg::MASK_CLEAR) begin
         action.act = mtte_pkg::ACT_CLEAR;
      end else if (key_mask == mtte_pkg::MASK_SPACE) begin
         action.act = mtte_pkg::ACT_SPACE;
      end else if (|key_mask) begin
         action.act = mtte_pkg::ACT_KEY;
      end else begin
         action.act = mtte_pkg::ACT_NONE;
      end
   end

endmodule

>>> rtl/core/multi_tap_text_entry.sv
// Multi-tap text entry top level: input register, text state, result register.
// Uses mtte_pkg, mtte_chan_if and mtte_key_decode.
//
//   channel  dir  payload                                   handshake
//   req_if   in   key_mask                                  valid/ready
//   rsp_if   out  char_0..char_7, letter_mode, press_count  valid/ready
//
// One word per cycle unless stalled; each word passes input then result register.
// Every poll gives one result word, also when no key is pressed.
// Reset (synchronous) sets an all-space text, no cursor, alphabet mode, count 0.
// A stalled result holds both stages; req_if.ready drops only when both are full.
module multi_tap_text_entry #(
   parameter int TEXT_LEN = mtte_pkg::TEXT_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   mtte_chan_if.sink    req_if,
   mtte_chan_if.source  rsp_if
);

   localparam int CW = $clog2(TEXT_LEN);
   localparam logic [CW-1:0] CUR_LAST = CW'(TEXT_LEN - 1);

   logic                          in_valid_ff, in_valid_in;
   logic [mtte_pkg::NUM_KEYS-1:0] in_mask_ff;
   logic                          out_valid_ff, out_valid_in;
   mtte_pkg::rsp_word_type        out_word_ff, out_word_in;

   mtte_pkg::char_type text_ff [TEXT_LEN];
   mtte_pkg::char_type text_in [TEXT_LEN];
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic               empty_ff, empty_in;
   logic [1:0]         tap_ff, tap_in;
   logic               last_valid_ff, last_valid_in;
   logic [3:0]         last_key_ff, last_key_in;
   mtte_pkg::char_type pending_ff, pending_in;
   logic               alpha_ff, alpha_in;
   logic [15:0]        count_ff, count_in;

   logic                 advance;
   logic                 step;
   logic                 advance_cursor;
   logic                 shift_text;
   logic                 clear_text;
   mtte_pkg::action_type action;
   mtte_pkg::char_type   out_chars [mtte_pkg::OUT_CHARS];

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   mtte_key_decode u_decode (
      .key_mask (in_mask_ff),
      .action   (action)
   );

   always_comb begin
      count_in       = count_ff;
      alpha_in       = alpha_ff;
      tap_in         = tap_ff;
      last_valid_in  = last_valid_ff;
      last_key_in    = last_key_ff;
      pending_in     = pending_ff;
      advance_cursor = 1'b0;
      clear_text     = 1'b0;
      unique case (action.act)
         mtte_pkg::ACT_TOGGLE: begin
            count_in = mtte_pkg::bcd_inc(count_ff);
            alpha_in = !alpha_ff;
         end
         mtte_pkg::ACT_CLEAR: begin
            count_in      = mtte_pkg::bcd_inc(count_ff);
            clear_text    = 1'b1;
            tap_in        = 2'd0;
            last_valid_in = 1'b0;
         end
         mtte_pkg::ACT_SPACE: begin
            count_in       = mtte_pkg::bcd_inc(count_ff);
            advance_cursor = 1'b1;
            pending_in     = mtte_pkg::CHAR_SPACE;
            tap_in         = 2'd0;
            last_valid_in  = 1'b0;
         end
         mtte_pkg::ACT_KEY: begin
            count_in = mtte_pkg::bcd_inc(count_ff);
            if (alpha_ff) begin
               if (!last_valid_ff || last_key_ff != action.key) begin
                  advance_cursor = 1'b1;
                  last_valid_in  = 1'b1;
                  last_key_in    = action.key;
                  tap_in         = 2'd0;
               end else begin
                  tap_in = (tap_ff >= mtte_pkg::TAP_LAST) ? 2'd0 : tap_ff + 2'd1;
               end
               pending_in = mtte_pkg::key_letter(action.key, tap_in);
            end else begin
               advance_cursor = 1'b1;
               pending_in     = mtte_pkg::CHAR_ZERO + 8'(action.key) + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cursor_in  = cursor_ff;
      empty_in   = empty_ff;
      shift_text = 1'b0;
      if (clear_text) begin
         cursor_in = '0;
         empty_in  = 1'b1;
      end else if (advance_cursor) begin
         if (empty_ff) begin
            cursor_in = '0;
            empty_in  = 1'b0;
         end else if (cursor_ff == CUR_LAST) begin
            shift_text = 1'b1;
         end else begin
            cursor_in = cursor_ff + 1'b1;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < TEXT_LEN; j++) begin
         if (clear_text) begin
            text_in[j] = mtte_pkg::CHAR_SPACE;
         end else if (shift_text && j < TEXT_LEN - 1) begin
            text_in[j] = text_ff[(j + 1) % TEXT_LEN];
         end else begin
            text_in[j] = text_ff[j];
         end
         // pending character is rewritten at the cursor on every word unless the text is empty
         if (!empty_in && cursor_in == CW'(j)) begin
            text_in[j] = pending_in;
         end
      end
   end

   for (genvar k = 0; k < mtte_pkg::OUT_CHARS; k++) begin : g_out_char
      if (k < TEXT_LEN) begin : g_text
         assign out_chars[k] = text_in[k];
      end else begin : g_blank
         assign out_chars[k] = mtte_pkg::CHAR_SPACE;
      end
   end

   always_comb begin
      out_word_in.char_0          = out_chars[0];
      out_word_in.char_1          = out_chars[1];
      out_word_in.char_2          = out_chars[2];
      out_word_in.char_3          = out_chars[3];
      out_word_in.char_4          = out_chars[4];
      out_word_in.char_5          = out_chars[5];
      out_word_in.char_6          = out_chars[6];
      out_word_in.char_7          = out_chars[7];
      out_word_in.letter_mode     = alpha_in;
      out_word_in.press_count_bcd = count_in;
   end

   always_comb begin
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_mask_ff <= req_if.payload.key_mask;
      end
      if (step) begin
         out_word_ff <= out_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         cursor_ff     <= '0;
         empty_ff      <= 1'b1;
         tap_ff        <= 2'd0;
         last_valid_ff <= 1'b0;
         last_key_ff   <= 4'd0;
         pending_ff    <= '0;
         alpha_ff      <= 1'b1;
         count_ff      <= '0;
         for (int j = 0; j < TEXT_LEN; j++) begin
            text_ff[j] <= mtte_pkg::CHAR_SPACE;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            cursor_ff     <= cursor_in;
            empty_ff      <= empty_in;
            tap_ff        <= tap_in;
            last_valid_ff <= last_valid_in;
            last_key_ff   <= last_key_in;
            pending_ff    <= pending_in;
            alpha_ff      <= alpha_in;
            count_ff      <= count_in;
            for (int j = 0; j < TEXT_LEN; j++) begin
               text_ff[j] <= text_in[j];
            end
         end
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_word_ff;

`ifndef SYNTHESIS
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff <= mtte_pkg::TAP_LAST)
      else $error("tap index out of range");

   a_count_bcd: assert property (@(posedge clock) disable iff (reset)
      count_ff[3:0] <= mtte_pkg::BCD_MAX_DIGIT && count_ff[7:4] <= mtte_pkg::BCD_MAX_DIGIT
      && count_ff[11:8] <= mtte_pkg::BCD_MAX_DIGIT
      && count_ff[15:12] <= mtte_pkg::BCD_MAX_DIGIT)
      else $error("press count not BCD");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      step && action.act == mtte_pkg::ACT_CLEAR |=> empty_ff && tap_ff == 2'd0)
      else $error("clear did not empty the text");

   a_step_gives_word: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff && out_word_ff.press_count_bcd == count_ff)
      else $error("processed word not presented");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |=> $stable(count_ff) && $stable(cursor_ff))
      else $error("state moved while result stalled");
`endif

endmodule

>>> verif/mtte_text_checker.sv
`timescale 1ns / 100ps
// Display checker for multi_tap_text_entry: predicts the text, mode and BCD press
// count for every accepted key word and compares each result word field by field.
// Depends on mtte_pkg.
module mtte_text_checker
   import mtte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           words_due
);

   localparam int TEXT_CHARS = TEXT_LEN_DEF;
   localparam logic [8*27-1:0] LETTER_ROWS = ".QZABCDEFGHIJKLMNOPRSTUVWXY";

   char_type     shown_text [TEXT_CHARS];
   int           cur_pos;
   logic [1:0]   tap_cnt;
   int           prev_key;
   char_type     held_char;
   logic         alpha_mode;
   logic [15:0]  press_bcd;
   rsp_word_type expected_displays [$];
   int           errs;

   function automatic logic [15:0] count_up_bcd(logic [15:0] v);
      logic [15:0] r;
      logic [4:0]  d;
      logic        c;
      r = '0;
      c = 1'b1;
      for (int k = 0; k < 4; k++) begin
         d = {1'b0, v[4*k +: 4]};
         if (d > 5'd9) begin
            d = 5'd9;
         end
         d = d + 5'(c);
         if (d > 5'd9) begin
            d = '0;
            c = 1'b1;
         end else begin
            c = 1'b0;
         end
         r[4*k +: 4] = d[3:0];
      end
      return r;
   endfunction

   function automatic char_type letter_of(int key, logic [1:0] tap);
      int k;
      k = key * 3 + int'(tap);
      return LETTER_ROWS[8*(26-k) +: 8];
   endfunction

   function automatic void clear_display();
      for (int i = 0; i < TEXT_CHARS; i++) begin
         shown_text[i] = CHAR_SPACE;
      end
      cur_pos    = -1;
      tap_cnt    = '0;
      prev_key   = -1;
      held_char  = '0;
      alpha_mode = 1'b1;
      press_bcd  = '0;
   endfunction

   function automatic rsp_word_type next_display(logic [NUM_KEYS-1:0] mask);
      int           lo;
      int           hi;
      logic [2:0]   act;
      rsp_word_type w;
      lo = -1;
      hi = -1;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (mask[i]) begin
            if (lo < 0) begin
               lo = i;
            end else begin
               hi = i;
            end
         end
      end
      if (lo == 4 && hi == 5) act = ACT_TOGGLE;
      else if (lo == 1 && hi == 2) act = ACT_CLEAR;
      else if (lo == 7 && hi == 8) act = ACT_SPACE;
      else if (lo >= 0) act = ACT_KEY;
      else act = ACT_NONE;

      if (act != ACT_NONE) begin
         press_bcd = count_up_bcd(press_bcd);
      end
      case (act)
         ACT_TOGGLE: begin
            alpha_mode = ~alpha_mode;
         end
         ACT_CLEAR: begin
            cur_pos  = -1;
            tap_cnt  = '0;
            prev_key = -1;
            for (int i = 0; i < TEXT_CHARS; i++) begin
               shown_text[i] = CHAR_SPACE;
            end
         end
         ACT_SPACE: begin
            cur_pos++;
            held_char = CHAR_SPACE;
            prev_key  = -1;
            tap_cnt   = '0;
         end
         ACT_KEY: begin
            if (alpha_mode) begin
               if (lo != prev_key) begin
                  cur_pos++;
                  prev_key = lo;
                  tap_cnt  = '0;
               end else begin
                  tap_cnt = (tap_cnt == TAP_LAST) ? 2'd0 : tap_cnt + 2'd1;
               end
               held_char = letter_of(lo, tap_cnt);
            end else begin
               cur_pos++;
               held_char = CHAR_ZERO + char_type'(lo + 1);
            end
         end
         default: ;
      endcase

      if (cur_pos > TEXT_CHARS - 1) begin
         cur_pos = TEXT_CHARS - 1;
         for (int i = 0; i < TEXT_CHARS - 1; i++) begin
            shown_text[i] = shown_text[i+1];
         end
      end
      if (cur_pos >= 0) begin
         shown_text[cur_pos] = held_char;
      end

      w.char_0          = shown_text[0];
      w.char_1          = shown_text[1];
      w.char_2          = shown_text[2];
      w.char_3          = shown_text[3];
      w.char_4          = shown_text[4];
      w.char_5          = shown_text[5];
      w.char_6          = shown_text[6];
      w.char_7          = shown_text[7];
      w.letter_mode     = alpha_mode;
      w.press_count_bcd = press_bcd;
      return w;
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] got_val);
      if (exp_val !== got_val) begin
         $error("%s: expected %h, got %h", name, exp_val, got_val);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_display();
         expected_displays.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_displays.size() == 0) begin
               $error("result word with no expectation pending");
               errs++;
            end else begin
               want = expected_displays.pop_front();
               check_field("char_0", 16'(want.char_0), 16'(rsp_word.char_0));
               check_field("char_1", 16'(want.char_1), 16'(rsp_word.char_1));
               check_field("char_2", 16'(want.char_2), 16'(rsp_word.char_2));
               check_field("char_3", 16'(want.char_3), 16'(rsp_word.char_3));
               check_field("char_4", 16'(want.char_4), 16'(rsp_word.char_4));
               check_field("char_5", 16'(want.char_5), 16'(rsp_word.char_5));
               check_field("char_6", 16'(want.char_6), 16'(rsp_word.char_6));
               check_field("char_7", 16'(want.char_7), 16'(rsp_word.char_7));
               check_field("letter_mode", 16'(want.letter_mode),
                           16'(rsp_word.letter_mode));
               check_field("press_count_bcd", want.press_count_bcd,
                           rsp_word.press_count_bcd);
            end
         end
         if (req_valid && req_ready) begin
            expected_displays.push_back(next_display(req_word.key_mask));
         end
      end
      fail_count <= errs;
      words_due  <= expected_displays.size();
   end

endmodule

>>> verif/multi_tap_text_entry_test.sv
`timescale 1ns / 100ps
// Top of the multi_tap_text_entry testbench: clock, reset, key word stimulus,
// random result stalls, watchdog and verdict. Uses mtte_pkg, mtte_chan_if, mtte_text_checker.
module multi_tap_text_entry_test;
   import mtte_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_POLLS = 700;
   localparam int STEADY_POLLS = 200;

   logic clock = 1'b0;
   logic reset;
   logic steady;
   int   fail_count;
   int   words_due;
   int   quiet_cycles;
   int   recent_key;

   mtte_chan_if #(.payload_type(req_word_type)) req_if ();
   mtte_chan_if #(.payload_type(rsp_word_type)) rsp_if ();

   multi_tap_text_entry DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   mtte_text_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_word   (req_if.payload),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_word   (rsp_if.payload),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("multi_tap_text_entry regression: fail");
         $finish;
      end
   end

   task automatic send_poll(logic [NUM_KEYS-1:0] mask);
      if (!steady && $urandom_range(99) < 35) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= req_word_type'{key_mask: mask};
      do @(posedge clock); while (!req_if.ready);
   endtask

   // mostly keying sequences with repeats, plus pairs, noise and empty polls
   function automatic logic [NUM_KEYS-1:0] pick_mask();
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         recent_key = $urandom_range(NUM_KEYS - 1);
         return NUM_KEYS'(1) << recent_key;
      end
      if (r < 60) return NUM_KEYS'(1) << recent_key;
      if (r < 70) return NUM_KEYS'($urandom_range(511));
      if (r < 77) return MASK_TOGGLE;
      if (r < 81) return MASK_CLEAR;
      if (r < 89) return MASK_SPACE;
      return '0;
   endfunction

   initial begin
      logic [NUM_KEYS-1:0] directed [] = '{
         9'h000, 9'h001, 9'h001, 9'h001, 9'h001, 9'h002, 9'h004, 9'h008,
         9'h010, 9'h020, 9'h040, MASK_TOGGLE, 9'h001, 9'h100, MASK_TOGGLE,
         9'h040, 9'h080, 9'h100, 9'h1FF, 9'h1FE, 9'h0F0, MASK_SPACE,
         MASK_CLEAR, MASK_CLEAR, 9'h100
      };
      reset          <= 1'b1;
      steady         <= 1'b0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      recent_key     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_poll(directed[i]);
      for (int n = 0; n < RANDOM_POLLS; n++) send_poll(pick_mask());

      // back-to-back keying with no idling on either side
      steady <= 1'b1;
      for (int n = 0; n < STEADY_POLLS; n++) send_poll(pick_mask() | 9'h001);
      steady <= 1'b0;
      for (int n = 0; n < 50; n++) send_poll(pick_mask());

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("multi_tap_text_entry regression: pass");
      end else begin
         $display("multi_tap_text_entry regression: fail");
      end
      $finish;
   end

endmodule
